// ----- rtl/core/gdad_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gdad_pkg
// Shared types, field widths, calendar constants and month length lookup
// for the Gregorian date adder.
// ----------------------------------------------------------------------------
package gdad_pkg;

    // transaction field widths
    localparam int unsigned YEAR_W   = 14;
    localparam int unsigned MONTH_W  = 4;
    localparam int unsigned DAY_W    = 5;
    localparam int unsigned ADD_W    = 22;
    localparam int unsigned STATUS_W = 2;

    localparam int unsigned DEF_YEAR_MAX = 9999;

    // days in a 400, 100, 4 and 1 year span
    localparam int unsigned DAYS_400 = 146097;
    localparam int unsigned DAYS_100 = 36524;
    localparam int unsigned DAYS_4   = 1461;
    localparam int unsigned DAYS_1   = 365;

    localparam int unsigned MONTHS = 12;

    // floor(x / 100) = (x * MUL100) >> MUL100_SH, exact for x below 2**16
    localparam int unsigned MUL100    = 83887;
    localparam int unsigned MUL100_SH = 23;
    localparam int unsigned MUL_W     = YEAR_W + 17;
    localparam int unsigned DIV100_W  = MUL_W - MUL100_SH;

    localparam logic [STATUS_W-1:0] STATUS_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_ILLEGAL = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_SAT     = 2'd2;

    localparam logic [DAY_W-1:0] MONTH_LEN_COMMON [MONTHS] =
        '{5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31};
    localparam logic [DAY_W-1:0] MONTH_LEN_LEAP [MONTHS] =
        '{5'd31, 5'd29, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31};

    // datapath commands from the controller
    typedef enum logic [3:0] {
        OP_IDLE,
        OP_LOAD,
        OP_PREP,
        OP_CHECK,
        OP_MONF,
        OP_ADD,
        OP_RANGE,
        OP_D400,
        OP_D100,
        OP_D4,
        OP_D1,
        OP_MONR,
        OP_OUT
    } op_t;

    // datapath status back to the controller
    typedef struct packed {
        logic illegal;
        logic ovf;
        logic done;
    } sts_t;

    // month length by zero based month index, zero for a nonexistent month
    function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] idx,
                                                   input logic leap);
        logic [DAY_W-1:0] len;
        if (idx > MONTH_W'(MONTHS - 1))
        begin
            len = '0;
        end
        else if (leap)
        begin
            len = MONTH_LEN_LEAP[idx];
        end
        else
        begin
            len = MONTH_LEN_COMMON[idx];
        end
        return len;
    endfunction

endpackage

// ----- rtl/core/gdad_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gdad_req_if / gdad_rsp_if
// Valid/ready channels carrying a start date request and a result date.
// ----------------------------------------------------------------------------
interface gdad_req_if import gdad_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [YEAR_W-1:0]  in_year;
    logic [MONTH_W-1:0] in_month;
    logic [DAY_W-1:0]   in_day;
    logic [ADD_W-1:0]   days_to_add;

    modport source (output valid, output in_year, output in_month, output in_day,
                    output days_to_add, input ready);
    modport sink   (input valid, input in_year, input in_month, input in_day,
                    input days_to_add, output ready);
endinterface

interface gdad_rsp_if import gdad_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [YEAR_W-1:0]   out_year;
    logic [MONTH_W-1:0]  out_month;
    logic [DAY_W-1:0]    out_day;
    logic [STATUS_W-1:0] status;

    modport source (output valid, output out_year, output out_month, output out_day,
                    output status, input ready);
    modport sink   (input valid, input out_year, input out_month, input out_day,
                    input status, output ready);
endinterface

// ----- rtl/core/gdad_datapath.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gdad_datapath
// Date to serial day conversion, day add, range check and the span by span
// conversion of the serial day back into a date.
// ----------------------------------------------------------------------------
module gdad_datapath import gdad_pkg::*; #(
    parameter int unsigned YEAR_MAX = DEF_YEAR_MAX
) (
    input  logic                clk,
    input  logic                rst_n,
    input  op_t                 op,
    output sts_t                sts,
    input  logic [YEAR_W-1:0]   in_year,
    input  logic [MONTH_W-1:0]  in_month,
    input  logic [DAY_W-1:0]    in_day,
    input  logic [ADD_W-1:0]    days_to_add,
    output logic [YEAR_W-1:0]   out_year,
    output logic [MONTH_W-1:0]  out_month,
    output logic [DAY_W-1:0]    out_day,
    output logic [STATUS_W-1:0] status
);

    // serial day of 31 december of the last year
    localparam int unsigned LIMIT = YEAR_MAX * 365 + YEAR_MAX / 4 - YEAR_MAX / 100
                                    + YEAR_MAX / 400;
    localparam int unsigned SER_W = $clog2(LIMIT + 2 ** ADD_W);
    localparam int unsigned QM    = LIMIT / DAYS_400;
    localparam int unsigned Q_W   = $clog2(QM + 1);
    localparam int unsigned KMAX  = (Q_W > 5) ? Q_W - 1 : 4;
    localparam int unsigned KB_W  = $clog2(KMAX + 1);
    localparam int unsigned YR_W  = $clog2(YEAR_MAX + 1);
    localparam int unsigned FW_W  = 25;
    localparam int unsigned P365_W = YEAR_W + 9;
    localparam logic [YEAR_W-1:0] YEAR_SAT = YEAR_W'(YEAR_MAX % (2 ** YEAR_W));

    logic [YEAR_W-1:0]   y_reg,      y_next;
    logic [MONTH_W-1:0]  m_reg,      m_next;
    logic [DAY_W-1:0]    d_reg,      d_next;
    logic [ADD_W-1:0]    add_reg,    add_next;
    logic [DIV100_W-1:0] ydiv_reg,   ydiv_next;
    logic [DIV100_W-1:0] pdiv_reg,   pdiv_next;
    logic [P365_W-1:0]   p365_reg,   p365_next;
    logic [SER_W-1:0]    ser_reg,    ser_next;
    logic                illegal_reg, illegal_next;
    logic                ovf_reg,    ovf_next;
    logic [MONTH_W-1:0]  mcnt_reg,   mcnt_next;
    logic [KB_W-1:0]     kbit_reg,   kbit_next;
    logic [YR_W-1:0]     yr_reg,     yr_next;
    logic [1:0]          q100_reg,   q100_next;
    logic [4:0]          q4_reg,     q4_next;
    logic [1:0]          q1_reg,     q1_next;
    logic [YEAR_W-1:0]   oyear_reg,  oyear_next;
    logic [MONTH_W-1:0]  omonth_reg, omonth_next;
    logic [DAY_W-1:0]    oday_reg,   oday_next;
    logic [STATUS_W-1:0] ostat_reg,  ostat_next;

    logic [YEAR_W-1:0]  p;
    logic [MUL_W-1:0]   yprod;
    logic [MUL_W-1:0]   pprod;
    logic [YEAR_W-1:0]  y_hund;
    logic               y_rem0;
    logic               leap_in;
    logic               leap_out;
    logic [DAY_W-1:0]   mlen_in;
    logic [DAY_W-1:0]   mlen_f;
    logic [DAY_W-1:0]   mlen_r;
    logic               illegal;
    logic [FW_W-1:0]    fw;
    logic [SER_W-1:0]   ser_sum;
    logic [SER_W-1:0]   dv400;
    logic [SER_W-1:0]   dv4;
    logic               ge400;
    logic               ge4;
    logic               ge100;
    logic               ge1;
    logic               monf_done;
    logic               monr_go;

    // input date checks
    assign p      = y_reg - YEAR_W'(1);
    assign yprod  = MUL_W'(y_reg) * MUL_W'(MUL100);
    assign pprod  = MUL_W'(p) * MUL_W'(MUL100);
    assign y_hund = YEAR_W'({ydiv_reg, 6'b0}) + YEAR_W'({ydiv_reg, 5'b0})
                  + YEAR_W'({ydiv_reg, 2'b0});
    assign y_rem0  = (y_reg == y_hund);
    assign leap_in = ((y_reg[1:0] == 2'b00) && !y_rem0)
                   || (y_rem0 && (ydiv_reg[1:0] == 2'b00));
    assign mlen_in = month_len(m_reg - MONTH_W'(1), leap_in);
    assign illegal = (y_reg == '0) || (32'(y_reg) > YEAR_MAX) || (m_reg == '0)
                   || (m_reg > MONTH_W'(MONTHS)) || (d_reg == '0) || (d_reg > mlen_in);

    // days before the start year: 365p + p/4 - p/100 + p/400
    assign fw = FW_W'(p365_reg) + FW_W'(p[YEAR_W-1:2]) - FW_W'(pdiv_reg)
              + FW_W'(pdiv_reg[DIV100_W-1:2]);

    // leap rule recovered from the span counts of the result year
    assign leap_out = (q1_reg == 2'd3) && ((q4_reg != 5'd24) || (q100_reg == 2'd3));
    assign mlen_f   = month_len(mcnt_reg, leap_in);
    assign mlen_r   = month_len(mcnt_reg, leap_out);

    assign ser_sum = ser_reg + SER_W'(d_reg) + SER_W'(add_reg);
    assign dv400   = SER_W'(DAYS_400) << kbit_reg;
    assign dv4     = SER_W'(DAYS_4) << kbit_reg;
    assign ge400   = (ser_reg >= dv400);
    assign ge4     = (ser_reg >= dv4);
    assign ge100   = (ser_reg >= SER_W'(DAYS_100));
    assign ge1     = (ser_reg >= SER_W'(DAYS_1));

    assign monf_done = ({1'b0, mcnt_reg} + 5'd1) >= {1'b0, m_reg};
    assign monr_go   = (mcnt_reg < MONTH_W'(MONTHS - 1)) && (ser_reg >= SER_W'(mlen_r));

    always_comb
    begin
        sts.illegal = illegal;
        sts.ovf     = (ser_reg > SER_W'(LIMIT));
        case (op)
            OP_MONF:  sts.done = monf_done;
            OP_D400:  sts.done = (kbit_reg == '0);
            OP_D100:  sts.done = (q100_reg == 2'd3) || !ge100;
            OP_D4:    sts.done = (kbit_reg == '0);
            OP_D1:    sts.done = (q1_reg == 2'd3) || !ge1;
            OP_MONR:  sts.done = !monr_go;
            default:  sts.done = 1'b0;
        endcase
    end

    always_comb
    begin
        y_next       = y_reg;
        m_next       = m_reg;
        d_next       = d_reg;
        add_next     = add_reg;
        ydiv_next    = ydiv_reg;
        pdiv_next    = pdiv_reg;
        p365_next    = p365_reg;
        ser_next     = ser_reg;
        illegal_next = illegal_reg;
        ovf_next     = ovf_reg;
        mcnt_next    = mcnt_reg;
        kbit_next    = kbit_reg;
        yr_next      = yr_reg;
        q100_next    = q100_reg;
        q4_next      = q4_reg;
        q1_next      = q1_reg;
        oyear_next   = oyear_reg;
        omonth_next  = omonth_reg;
        oday_next    = oday_reg;
        ostat_next   = ostat_reg;
        case (op)
            OP_LOAD:
            begin
                y_next       = in_year;
                m_next       = in_month;
                d_next       = in_day;
                add_next     = days_to_add;
                illegal_next = 1'b0;
                ovf_next     = 1'b0;
                mcnt_next    = '0;
            end
            OP_PREP:
            begin
                ydiv_next = yprod[MUL_W-1:MUL100_SH];
                pdiv_next = pprod[MUL_W-1:MUL100_SH];
                p365_next = P365_W'(p) * P365_W'(DAYS_1);
            end
            OP_CHECK:
            begin
                illegal_next = illegal;
                ser_next     = SER_W'(fw);
            end
            OP_MONF:
            begin
                if (!monf_done)
                begin
                    ser_next  = ser_reg + SER_W'(mlen_f);
                    mcnt_next = mcnt_reg + MONTH_W'(1);
                end
            end
            OP_ADD:
            begin
                ser_next = ser_sum;
            end
            OP_RANGE:
            begin
                ovf_next  = sts.ovf;
                ser_next  = ser_reg - SER_W'(1);
                mcnt_next = '0;
                kbit_next = KB_W'(Q_W - 1);
                yr_next   = YR_W'(1);
                q100_next = '0;
                q4_next   = '0;
                q1_next   = '0;
            end
            OP_D400:
            begin
                if (ge400)
                begin
                    ser_next = ser_reg - dv400;
                    yr_next  = yr_reg + YR_W'(32'(400) << kbit_reg);
                end
                if (kbit_reg == '0)
                begin
                    kbit_next = KB_W'(4);
                end
                else
                begin
                    kbit_next = kbit_reg - KB_W'(1);
                end
            end
            OP_D100:
            begin
                if ((q100_reg != 2'd3) && ge100)
                begin
                    ser_next  = ser_reg - SER_W'(DAYS_100);
                    yr_next   = yr_reg + YR_W'(100);
                    q100_next = q100_reg + 2'd1;
                end
            end
            OP_D4:
            begin
                if (ge4)
                begin
                    ser_next = ser_reg - dv4;
                    yr_next  = yr_reg + YR_W'(32'(4) << kbit_reg);
                    q4_next  = q4_reg | (5'd1 << kbit_reg);
                end
                if (kbit_reg != '0)
                begin
                    kbit_next = kbit_reg - KB_W'(1);
                end
            end
            OP_D1:
            begin
                if ((q1_reg != 2'd3) && ge1)
                begin
                    ser_next = ser_reg - SER_W'(DAYS_1);
                    yr_next  = yr_reg + YR_W'(1);
                    q1_next  = q1_reg + 2'd1;
                end
            end
            OP_MONR:
            begin
                if (monr_go)
                begin
                    ser_next  = ser_reg - SER_W'(mlen_r);
                    mcnt_next = mcnt_reg + MONTH_W'(1);
                end
            end
            OP_OUT:
            begin
                if (illegal_reg)
                begin
                    oyear_next  = '0;
                    omonth_next = '0;
                    oday_next   = '0;
                    ostat_next  = STATUS_ILLEGAL;
                end
                else if (ovf_reg)
                begin
                    oyear_next  = YEAR_SAT;
                    omonth_next = MONTH_W'(MONTHS);
                    oday_next   = DAY_W'(31);
                    ostat_next  = STATUS_SAT;
                end
                else
                begin
                    oyear_next  = YEAR_W'(yr_reg);
                    omonth_next = mcnt_reg + MONTH_W'(1);
                    oday_next   = DAY_W'(ser_reg) + DAY_W'(1);
                    ostat_next  = STATUS_OK;
                end
            end
            default:
            begin
            end
        endcase
    end

    // loop counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mcnt_reg <= '0;
            kbit_reg <= '0;
            q100_reg <= '0;
            q4_reg   <= '0;
            q1_reg   <= '0;
        end
        else
        begin
            mcnt_reg <= mcnt_next;
            kbit_reg <= kbit_next;
            q100_reg <= q100_next;
            q4_reg   <= q4_next;
            q1_reg   <= q1_next;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        y_reg       <= y_next;
        m_reg       <= m_next;
        d_reg       <= d_next;
        add_reg     <= add_next;
        ydiv_reg    <= ydiv_next;
        pdiv_reg    <= pdiv_next;
        p365_reg    <= p365_next;
        ser_reg     <= ser_next;
        illegal_reg <= illegal_next;
        ovf_reg     <= ovf_next;
        yr_reg      <= yr_next;
        oyear_reg   <= oyear_next;
        omonth_reg  <= omonth_next;
        oday_reg    <= oday_next;
        ostat_reg   <= ostat_next;
    end

    assign out_year  = oyear_reg;
    assign out_month = omonth_reg;
    assign out_day   = oday_reg;
    assign status    = ostat_reg;

endmodule

// ----- rtl/core/gdad_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gdad_ctrl
// Sequencer that steps the datapath through one transaction and owns the
// handshake on both channels.
// ----------------------------------------------------------------------------
module gdad_ctrl import gdad_pkg::*; (
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    output logic req_ready,
    output logic rsp_valid,
    input  logic rsp_ready,
    output op_t  op,
    input  sts_t sts
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_PREP,
        S_CHECK,
        S_MONF,
        S_ADD,
        S_RANGE,
        S_D400,
        S_D100,
        S_D4,
        S_D1,
        S_MONR,
        S_OUT
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   out_free;

    assign out_free  = !out_valid_reg || rsp_ready;
    assign req_ready = (state_reg == S_IDLE);
    assign rsp_valid = out_valid_reg;

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && !rsp_ready;
        op             = OP_IDLE;
        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    op         = OP_LOAD;
                    state_next = S_PREP;
                end
            end
            S_PREP:
            begin
                op         = OP_PREP;
                state_next = S_CHECK;
            end
            S_CHECK:
            begin
                op         = OP_CHECK;
                state_next = sts.illegal ? S_OUT : S_MONF;
            end
            S_MONF:
            begin
                op = OP_MONF;
                if (sts.done)
                begin
                    state_next = S_ADD;
                end
            end
            S_ADD:
            begin
                op         = OP_ADD;
                state_next = S_RANGE;
            end
            S_RANGE:
            begin
                op         = OP_RANGE;
                state_next = sts.ovf ? S_OUT : S_D400;
            end
            S_D400:
            begin
                op = OP_D400;
                if (sts.done)
                begin
                    state_next = S_D100;
                end
            end
            S_D100:
            begin
                op = OP_D100;
                if (sts.done)
                begin
                    state_next = S_D4;
                end
            end
            S_D4:
            begin
                op = OP_D4;
                if (sts.done)
                begin
                    state_next = S_D1;
                end
            end
            S_D1:
            begin
                op = OP_D1;
                if (sts.done)
                begin
                    state_next = S_MONR;
                end
            end
            S_MONR:
            begin
                op = OP_MONR;
                if (sts.done)
                begin
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                if (out_free)
                begin
                    op             = OP_OUT;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// ----- rtl/core/gregorian_date_add_days.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gregorian_date_add_days
// Adds a day count to a Gregorian date and reports legality or saturation.
// ----------------------------------------------------------------------------
// usage
//   req carries one start date (year, month, day) and a day count per
//   transaction; rsp returns the resulting date and a status code
//   (ok, illegal start date, saturated at 31 december of YEAR_MAX)
//   one transaction is worked at a time: req.ready is high only while the
//   sequencer is idle
//   a transaction steps through load, date check, a month walk on the way
//   in (its length set by the start month), the add, the range check and a
//   walk on the way out (400 year spans one quotient bit a cycle, then 100,
//   4 and 1 year spans, then months) before the output step; a saturated
//   result skips the walk on the way out, an illegal date both walks
//   the result sits in an output register, so the next request is taken
//   while an earlier response still waits; a stalled rsp only holds the
//   sequencer at its final step until the register frees
//   reset clears the sequencer and the response valid; no transaction is
//   in flight after reset
// ----------------------------------------------------------------------------
module gregorian_date_add_days import gdad_pkg::*; #(
    parameter int unsigned YEAR_MAX = DEF_YEAR_MAX
) (
    input logic      clk,
    input logic      rst_n,
    gdad_req_if.sink req,
    gdad_rsp_if.source rsp
);

    op_t  op;
    sts_t sts;

    // sequencer: handshakes and step order
    gdad_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req.ready),
        .rsp_valid (rsp.valid),
        .rsp_ready (rsp.ready),
        .op        (op),
        .sts       (sts)
    );

    // datapath: serial day arithmetic and the result register
    gdad_datapath #(
        .YEAR_MAX (YEAR_MAX)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .op          (op),
        .sts         (sts),
        .in_year     (req.in_year),
        .in_month    (req.in_month),
        .in_day      (req.in_day),
        .days_to_add (req.days_to_add),
        .out_year    (rsp.out_year),
        .out_month   (rsp.out_month),
        .out_day     (rsp.out_day),
        .status      (rsp.status)
    );

endmodule

// ----- rtl/core/gdad_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gdad_checker
// Port level checks on the date adder, attached by bind.
// ----------------------------------------------------------------------------
module gdad_checker import gdad_pkg::*; (
    input logic                clk,
    input logic                rst_n,
    input logic                req_valid,
    input logic                req_ready,
    input logic                rsp_valid,
    input logic                rsp_ready,
    input logic [YEAR_W-1:0]   out_year,
    input logic [MONTH_W-1:0]  out_month,
    input logic [DAY_W-1:0]    out_day,
    input logic [STATUS_W-1:0] status
);

    // stalled response holds
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(out_year) && $stable(out_month)
                                    && $stable(out_day) && $stable(status))
        else $error("response changed while stalled");

    // one transaction at a time
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("request taken while busy");

    a_illegal_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (status == STATUS_ILLEGAL) |->
            (out_year == '0) && (out_month == '0) && (out_day == '0))
        else $error("illegal date result not cleared");

    a_ok_range: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (status == STATUS_OK) |->
            (out_year != '0) && (out_month != '0) && (out_month <= MONTH_W'(MONTHS))
            && (out_day != '0))
        else $error("result date out of range");

    a_sat_date: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (status == STATUS_SAT) |->
            (out_month == MONTH_W'(MONTHS)) && (out_day == DAY_W'(31)))
        else $error("saturated date not 12/31");

endmodule

bind gregorian_date_add_days gdad_checker u_gdad_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .out_year  (rsp.out_year),
    .out_month (rsp.out_month),
    .out_day   (rsp.out_day),
    .status    (rsp.status)
);

// ----- verif/tb_gregorian_date_add_days.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_gregorian_date_add_days
// Self-checking bench for the Gregorian date adder. A queue of start dates
// and day counts feeds a valid/ready driver. Each accepted request is run
// through a behavioral calendar model, and each response is checked field
// by field, in order, against it. The run starts with a directed set:
// range ends, illegal dates, leap rules, month ends and saturation. A
// random set follows, mostly legal dates with varied day counts, plus
// targeted near-limit sums and raw field noise. Both sides idle in random
// bursts, the receiver holds off once for a long stretch, and the sender
// once pauses until the block has drained.
// ----------------------------------------------------------------------------
module tb_gregorian_date_add_days import gdad_pkg::*; ();

    localparam int unsigned YEAR_LIMIT   = DEF_YEAR_MAX;
    localparam int unsigned ADD_MAX      = (1 << ADD_W) - 1;
    localparam int unsigned RANDOM_ITEMS = 1800;
    localparam int unsigned TAIL_ITEMS   = 150;     // no idling once this few are left
    localparam int unsigned DRAIN_AT     = 900;     // sender waits for an empty pipe here
    localparam int unsigned HOLD_AT      = 300;     // receiver long hold-off after this many
    localparam int unsigned HOLD_CYCLES  = 400;
    localparam int unsigned DRAIN_CYCLES = 100;     // well past the worst case latency
    localparam int unsigned CYCLE_LIMIT  = 1000000;
    localparam int unsigned MAX_REPORTS  = 40;

    typedef struct packed {
        logic [YEAR_W-1:0]  year;
        logic [MONTH_W-1:0] month;
        logic [DAY_W-1:0]   day;
        logic [ADD_W-1:0]   days;
    } date_req_t;

    typedef struct packed {
        logic [YEAR_W-1:0]   year;
        logic [MONTH_W-1:0]  month;
        logic [DAY_W-1:0]    day;
        logic [STATUS_W-1:0] status;
    } date_rsp_t;

    // a response we are waiting for, with the request that caused it
    typedef struct packed {
        date_req_t start;
        date_rsp_t want;
    } date_expect_t;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    // driver and receiver registers, known from time zero
    logic      src_valid  = 1'b0;
    date_req_t src_item   = '0;
    logic      sink_ready = 1'b0;

    date_req_t    req_backlog[$];       // requests not yet offered
    date_expect_t sum_expected[$];      // responses owed by the block, oldest first

    int unsigned error_count  = 0;
    int unsigned cycle_count  = 0;
    int unsigned sent_count   = 0;
    int unsigned results_seen = 0;
    int unsigned n_ok         = 0;
    int unsigned n_illegal    = 0;
    int unsigned n_saturated  = 0;
    bit          hold_done    = 1'b0;
    bit          drain_done   = 1'b0;

    gdad_req_if req_ch ();
    gdad_rsp_if rsp_ch ();

    assign req_ch.valid       = src_valid;
    assign req_ch.in_year     = src_item.year;
    assign req_ch.in_month    = src_item.month;
    assign req_ch.in_day      = src_item.day;
    assign req_ch.days_to_add = src_item.days;
    assign rsp_ch.ready       = sink_ready;

    gregorian_date_add_days #(
        .YEAR_MAX (YEAR_LIMIT)
    ) i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    always #4 clk = ~clk;

    // ------------------------------------------------------------------------
    // calendar model
    // ------------------------------------------------------------------------

    // divisible by 4, except centuries, except every fourth century
    function automatic bit is_leap(input int unsigned y);
        return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
    endfunction

    // month length by zero based month index
    function automatic int unsigned month_days(input int unsigned idx, input bit leap);
        return leap ? MONTH_LEN_LEAP[idx] : MONTH_LEN_COMMON[idx];
    endfunction

    // whole days in all years ahead of year y
    function automatic int unsigned days_before_year(input int unsigned y);
        int unsigned p;
        p = y - 1;
        return p * 365 + p / 4 - p / 100 + p / 400;
    endfunction

    // day number with 1 jan of year 1 as day 1, for a legal date
    function automatic int unsigned date_serial(input int unsigned y, input int unsigned m,
                                                input int unsigned d);
        int unsigned s;
        bit          leap;
        leap = is_leap(y);
        s    = days_before_year(y) + d;
        for (int unsigned i = 1; i < m; i++)
        begin
            s += month_days(i - 1, leap);
        end
        return s;
    endfunction

    function automatic date_rsp_t predict_date_sum(input date_req_t q);
        date_rsp_t   res;
        int unsigned serial;
        int unsigned rem;
        int unsigned q400;
        int unsigned q100;
        int unsigned q4;
        int unsigned q1;
        int unsigned yr;
        int unsigned mi;
        bit          leap;
        res        = '0;
        res.status = STATUS_ILLEGAL;
        // illegal start date answers with an all-zero date
        if (q.year == 0 || q.year > YEAR_LIMIT || q.month == 0 || q.month > MONTHS ||
            q.day == 0)
        begin
            return res;
        end
        if (q.day > month_days(q.month - 1, is_leap(q.year)))
        begin
            return res;
        end
        serial = date_serial(q.year, q.month, q.day) + q.days;
        // past 31 december of the last year: pin the date there
        if (serial > days_before_year(YEAR_LIMIT + 1))
        begin
            res.year   = YEAR_W'(YEAR_LIMIT);
            res.month  = MONTH_W'(12);
            res.day    = DAY_W'(31);
            res.status = STATUS_SAT;
            return res;
        end
        // peel off 400, 100, 4 and 1 year spans; the last year of a span
        // absorbs the leap day, hence the clamps at 3
        rem  = serial - 1;
        q400 = rem / DAYS_400;
        rem  = rem % DAYS_400;
        q100 = rem / DAYS_100;
        if (q100 > 3)
        begin
            q100 = 3;
        end
        rem -= q100 * DAYS_100;
        q4   = rem / DAYS_4;
        rem  = rem % DAYS_4;
        q1   = rem / DAYS_1;
        if (q1 > 3)
        begin
            q1 = 3;
        end
        rem -= q1 * DAYS_1;
        yr   = q400 * 400 + q100 * 100 + q4 * 4 + q1 + 1;
        // then walk the months; december takes whatever is left
        leap = is_leap(yr);
        mi   = 0;
        while (mi < MONTHS - 1 && rem >= month_days(mi, leap))
        begin
            rem -= month_days(mi, leap);
            mi++;
        end
        res.year   = YEAR_W'(yr);
        res.month  = MONTH_W'(mi + 1);
        res.day    = DAY_W'(rem + 1);
        res.status = STATUS_OK;
        return res;
    endfunction

    // ------------------------------------------------------------------------
    // helpers
    // ------------------------------------------------------------------------

    task automatic add_request(input int unsigned y, input int unsigned m,
                               input int unsigned d, input int unsigned n);
        req_backlog.push_back('{YEAR_W'(y), MONTH_W'(m), DAY_W'(d), ADD_W'(n)});
    endtask

    // idle rate for the next stretch: none, light or heavy
    function automatic int unsigned pick_idle_pct();
        case ($urandom_range(0, 2))
            0:       return 0;
            1:       return 8;
            default: return 30;
        endcase
    endfunction

    task automatic flag_mismatch(input string what);
        error_count++;
        if (error_count <= MAX_REPORTS)
        begin
            $display("MISMATCH @%0t: %s", $time, what);
        end
    endtask

    function automatic string field_note(input string fname, input date_expect_t e,
                                         input int unsigned got_val);
        return $sformatf("%s got %0d want %0d for start %0d-%0d-%0d plus %0d days",
                         fname, got_val,
                         fname == "out_year"  ? e.want.year  :
                         fname == "out_month" ? e.want.month :
                         fname == "out_day"   ? e.want.day   : e.want.status,
                         e.start.year, e.start.month, e.start.day, e.start.days);
    endfunction

    // ------------------------------------------------------------------------
    // request driver
    // ------------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin : req_driver
        int unsigned src_gap;
        int unsigned src_idle_pct;
        bit          tail;
        if (!rst_n)
        begin
            src_valid    <= 1'b0;
            src_item     <= '0;
            src_gap      = 0;
            src_idle_pct = 0;
        end
        else
        begin
            // accepted transaction: work out the response it owes
            if (src_valid && req_ch.ready)
            begin
                sum_expected.push_back('{src_item, predict_date_sum(src_item)});
            end
            tail = req_backlog.size() < TAIL_ITEMS;
            // the bus is free for a new transaction only when the last one went
            if (!src_valid || req_ch.ready)
            begin
                if (src_gap != 0)
                begin
                    src_gap--;
                    src_valid <= 1'b0;
                end
                else if (sent_count == DRAIN_AT && sum_expected.size() != 0)
                begin
                    // one pause until the block has handed back everything
                    src_valid  <= 1'b0;
                    drain_done = 1'b1;
                end
                else if (req_backlog.size() == 0)
                begin
                    src_valid <= 1'b0;
                end
                else if (!tail && $urandom_range(0, 99) < src_idle_pct)
                begin
                    src_gap = $urandom_range(1, 18) - 1;
                    src_valid <= 1'b0;
                end
                else
                begin
                    src_item  <= req_backlog.pop_front();
                    src_valid <= 1'b1;
                    sent_count++;
                    if (sent_count % 64 == 0)
                    begin
                        src_idle_pct = pick_idle_pct();
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // response monitor and receiver
    // ------------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin : rsp_monitor
        date_rsp_t    got;
        date_expect_t slot;
        int unsigned  sink_gap;
        int unsigned  sink_idle_pct;
        int unsigned  hold_left;
        bit           tail;
        if (!rst_n)
        begin
            sink_ready    <= 1'b0;
            sink_gap      = 0;
            sink_idle_pct = 0;
            hold_left     = 0;
        end
        else
        begin
            if (rsp_ch.valid && sink_ready)
            begin
                got = '{rsp_ch.out_year, rsp_ch.out_month, rsp_ch.out_day, rsp_ch.status};
                case (got.status)
                    STATUS_OK:      n_ok++;
                    STATUS_ILLEGAL: n_illegal++;
                    default:        n_saturated++;
                endcase
                if (sum_expected.size() == 0)
                begin
                    flag_mismatch($sformatf("response %0d-%0d-%0d status %0d with none owed",
                                            got.year, got.month, got.day, got.status));
                end
                else
                begin
                    slot = sum_expected.pop_front();
                    if (got.year != slot.want.year)
                    begin
                        flag_mismatch(field_note("out_year", slot, got.year));
                    end
                    if (got.month != slot.want.month)
                    begin
                        flag_mismatch(field_note("out_month", slot, got.month));
                    end
                    if (got.day != slot.want.day)
                    begin
                        flag_mismatch(field_note("out_day", slot, got.day));
                    end
                    if (got.status != slot.want.status)
                    begin
                        flag_mismatch(field_note("status", slot, got.status));
                    end
                end
                results_seen++;
                if (results_seen % 64 == 0)
                begin
                    sink_idle_pct = pick_idle_pct();
                end
                // one long hold-off so the output register fills and req stalls
                if (results_seen == HOLD_AT)
                begin
                    hold_left = HOLD_CYCLES;
                    hold_done = 1'b1;
                end
            end
            tail = req_backlog.size() < TAIL_ITEMS;
            if (hold_left != 0)
            begin
                hold_left--;
                sink_ready <= 1'b0;
            end
            else if (sink_gap != 0)
            begin
                sink_gap--;
                sink_ready <= 1'b0;
            end
            else if (!tail && $urandom_range(0, 99) < sink_idle_pct)
            begin
                sink_gap = $urandom_range(1, 18) - 1;
                sink_ready <= 1'b0;
            end
            else
            begin
                sink_ready <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------------
    // watchdog
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d responses still owed",
                     cycle_count, sum_expected.size());
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // stimulus and end of run
    // ------------------------------------------------------------------------
    initial
    begin : stimulus
        int unsigned y;
        int unsigned m;
        int unsigned d;
        int unsigned n;
        int unsigned len;
        int unsigned sel;
        int          near_n;

        // directed: range ends, illegal fields, leap rules, month ends, saturation
        add_request(1, 1, 1, 0);                     // first day of the calendar
        add_request(YEAR_LIMIT, 12, 31, 0);          // last day, still in range
        add_request(YEAR_LIMIT, 12, 31, 1);          // one past the last day
        add_request(1, 1, 1, ADD_MAX);               // largest count
        add_request(1, 1, 1, date_serial(YEAR_LIMIT, 12, 31) - 1);  // lands on the last day
        add_request(YEAR_LIMIT, 1, 1, 364);
        add_request(YEAR_LIMIT, 1, 1, 365);
        add_request(0, 6, 15, 10);                   // year zero
        add_request(YEAR_LIMIT + 1, 1, 1, 0);        // year above the range
        add_request((1 << YEAR_W) - 1, 15, 31, ADD_MAX);  // every field all ones
        add_request(2023, 0, 1, 5);                  // month zero
        add_request(2023, 13, 1, 5);                 // month above december
        add_request(2023, 5, 0, 5);                  // day zero
        add_request(2023, 4, 31, 0);                 // day past a 30 day month
        add_request(1900, 2, 29, 0);                 // century, not leap
        add_request(2000, 2, 29, 0);                 // fourth century, leap
        add_request(2023, 2, 29, 0);
        add_request(2024, 2, 28, 1);                 // into the leap day
        add_request(2023, 2, 28, 1);                 // straight to march
        add_request(2023, 12, 31, 0);                // december is legal
        add_request(1999, 12, 31, 1);                // year roll
        add_request(2023, 1, 30, 1);                 // must land on the 31st, not day 0
        add_request(1, 1, 1, DAYS_100 - 1);          // end of the first century
        add_request(1, 1, 1, DAYS_400 - 1);          // end of the first 400 year span
        add_request(1, 1, 1, DAYS_400);

        // random: mostly legal starts with counts from tiny to full width
        for (int unsigned k = 0; k < RANDOM_ITEMS; k++)
        begin
            sel = $urandom_range(0, 99);
            if (sel >= 70 && sel < 80 && $urandom_range(0, 1) == 1)
            begin
                y = $urandom_range(YEAR_LIMIT - 40, YEAR_LIMIT);
            end
            else
            begin
                y = $urandom_range(1, YEAR_LIMIT);
            end
            m   = $urandom_range(1, MONTHS);
            len = month_days(m - 1, is_leap(y));
            d   = $urandom_range(1, len);
            if (sel < 35)
            begin
                n = $urandom_range(0, 400);
            end
            else if (sel < 55)
            begin
                n = $urandom_range(0, 60000);
            end
            else if (sel < 70)
            begin
                n = $urandom_range(0, ADD_MAX);
            end
            else if (sel < 80)
            begin
                // sum a few days either side of the saturation point
                near_n = int'(days_before_year(YEAR_LIMIT + 1) - date_serial(y, m, d)) +
                         int'($urandom_range(0, 6)) - 3;
                n      = (near_n < 0) ? 0 : near_n;
            end
            else if (sel < 86)
            begin
                d = len;                         // start on a month end
                n = $urandom_range(0, 2);
            end
            else if (sel < 92)
            begin
                d = (len < 31) ? $urandom_range(len + 1, 31) : 0;
                n = $urandom_range(0, 1000);
            end
            else
            begin
                // raw field noise, mostly illegal
                y = $urandom_range(0, (1 << YEAR_W) - 1);
                m = $urandom_range(0, (1 << MONTH_W) - 1);
                d = $urandom_range(0, (1 << DAY_W) - 1);
                n = $urandom_range(0, ADD_MAX);
            end
            add_request(y, m, d, n);
        end

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // wait for the last request to be taken, then for every response
        while (req_backlog.size() != 0 || src_valid)
        begin
            @(posedge clk);
        end
        while (sum_expected.size() != 0)
        begin
            @(posedge clk);
        end
        // stray responses would show up here
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("checked %0d responses: %0d in range, %0d illegal start, %0d saturated",
                 results_seen, n_ok, n_illegal, n_saturated);
        $display("long receiver hold-off %s, sender drain pause %s, %0d mismatches",
                 hold_done ? "done" : "missed", drain_done ? "done" : "missed", error_count);
        if (error_count == 0 && sum_expected.size() == 0)
        begin
            $display("RESULT: OK");
        end
        else
        begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

// ----- files.f -----
rtl/core/gdad_pkg.sv
rtl/core/gdad_if.sv
rtl/core/gdad_datapath.sv
rtl/core/gdad_ctrl.sv
rtl/core/gregorian_date_add_days.sv
rtl/core/gdad_checker.sv
verif/tb_gregorian_date_add_days.sv
